/* hdl/olids_pkg.sv */
// ----------------------------------------------------------------------------
// olids_pkg: shared types and constants for the ordered list unit
// Depth, field widths, operation and status codes, and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package olids_pkg;

    localparam int DEPTH         = 16;
    localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int DATA_W        = 32;
    localparam int POSITION_W    = 4;
    localparam int ENTRY_COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RSVD      = 2'd3
    } status_t;

    // Broadcast to every cell for one operation.
    typedef struct packed {
        logic                     insert;  // shift toward the back
        logic                     remove;  // close the gap behind the first hit
        logic signed [DATA_W-1:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/olids_cell.sv */
// ----------------------------------------------------------------------------
// olids_cell: one slot of the ordered list
// Holds one entry, compares it with the key and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module olids_cell (
    input  wire logic                             clk,
    input  wire olids_pkg::cell_ctrl_t            ctrl,
    input  wire logic                             valid,
    input  wire logic signed [olids_pkg::DATA_W-1:0] prev_entry,
    input  wire logic signed [olids_pkg::DATA_W-1:0] next_entry,
    input  wire logic                             hit_in,
    output logic                                  hit_out,
    output logic                                  first_hit,
    output logic signed [olids_pkg::DATA_W-1:0]   entry
);

    logic signed [olids_pkg::DATA_W-1:0] entry_reg;
    logic                                match;

    assign match     = valid && (entry_reg == ctrl.key);
    assign hit_out   = hit_in | match;
    assign first_hit = match & ~hit_in;
    assign entry     = entry_reg;

    // shift toward the back on insert; at or behind the first hit, pull from the back neighbor on delete
    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            entry_reg <= prev_entry;
        end
        else if (ctrl.remove && hit_out)
        begin
            entry_reg <= next_entry;
        end
    end

endmodule

`default_nettype wire

/* hdl/ordered_list_insert_delete_search_unit.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search_unit: ordered list of signed words
// Insert at front, delete first match, search first match over a cell row.
// ----------------------------------------------------------------------------
// The result word is shown with done in the cycle after start is taken.
// Throughput: one word per cycle; busy stays low, since every
// cell compares and shifts in the same cycle the word is taken.
// Reset: the entry count clears; cell contents stay undefined until written.
// The receiver cannot stall: done pulses for exactly one cycle per word.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_delete_search_unit (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     start,
    output logic                                          busy,
    input  wire logic [1:0]                               operation,
    input  wire logic signed [olids_pkg::DATA_W-1:0]      value,
    output logic                                          done,
    output logic [1:0]                                    status,
    output logic [olids_pkg::POSITION_W-1:0]              position,
    output logic [olids_pkg::ENTRY_COUNT_W-1:0]           entry_count
);

    localparam int N = olids_pkg::DEPTH;

    // ---- control state --------------------------------------------------
    logic [olids_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                             done_reg;
    olids_pkg::status_t               status_reg, status_next;
    logic [olids_pkg::IDX_W-1:0]      position_reg, position_next;

    // ---- cell row wiring ------------------------------------------------
    olids_pkg::cell_ctrl_t            ctrl;
    logic signed [olids_pkg::DATA_W-1:0] entries [N];
    logic [N:0]                       hit;      // running "match seen" chain
    logic [N-1:0]                     first;    // one-hot first match
    logic [N-1:0]                     valid;
    logic                             accept;
    logic                             full;
    logic                             found;
    olids_pkg::op_t                   op;

    assign busy   = 1'b0;               // never stalls
    assign accept = start & ~busy;
    assign op     = olids_pkg::op_t'(operation);
    assign full   = (count_reg == olids_pkg::CNT_W'(N));
    assign found  = hit[N];
    assign hit[0] = 1'b0;

    assign ctrl.key    = value;
    assign ctrl.insert = accept && (op == olids_pkg::OP_INSERT) && !full;
    assign ctrl.remove = accept && (op == olids_pkg::OP_DELETE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic signed [olids_pkg::DATA_W-1:0] prev_e;
            logic signed [olids_pkg::DATA_W-1:0] next_e;

            // front cell takes the new word; back cell has no neighbor
            if (gi == 0)
            begin : g_front
                assign prev_e = value;
            end
            else
            begin : g_mid_prev
                assign prev_e = entries[gi-1];
            end

            if (gi == N - 1)
            begin : g_back
                assign next_e = entries[gi];
            end
            else
            begin : g_mid_next
                assign next_e = entries[gi+1];
            end

            assign valid[gi] = (olids_pkg::CNT_W'(gi) < count_reg);

            olids_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (valid[gi]),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .hit_in     (hit[gi]),
                .hit_out    (hit[gi+1]),
                .first_hit  (first[gi]),
                .entry      (entries[gi])
            );
        end
    endgenerate

    // ---- first-match index: OR of indexes, first is one-hot -------------
    always_comb
    begin
        position_next = '0;
        for (int i = 0; i < N; i++)
        begin
            if (first[i])
            begin
                position_next = position_next | olids_pkg::IDX_W'(i);
            end
        end
    end

    // ---- status and count update ----------------------------------------
    always_comb
    begin
        count_next  = count_reg;
        status_next = olids_pkg::ST_OK;
        case (op)
            olids_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = olids_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + olids_pkg::CNT_W'(1);
                end
            end
            olids_pkg::OP_DELETE:
            begin
                if (found)
                begin
                    count_next = count_reg - olids_pkg::CNT_W'(1);
                end
                else
                begin
                    status_next = olids_pkg::ST_NOT_FOUND;
                end
            end
            olids_pkg::OP_SEARCH:
            begin
                if (!found)
                begin
                    status_next = olids_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = olids_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload; position is zero unless a match is reported
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            if ((op == olids_pkg::OP_DELETE || op == olids_pkg::OP_SEARCH) && found)
            begin
                position_reg <= position_next;
            end
            else
            begin
                position_reg <= '0;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = olids_pkg::POSITION_W'(position_reg);
    assign entry_count = olids_pkg::ENTRY_COUNT_W'(count_reg);

    // ---- checks ---------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= olids_pkg::CNT_W'(N))
        else $error("entry count above depth");

    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first))
        else $error("more than one first match");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted word gave no result");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == olids_pkg::ST_FULL) |-> full)
        else $error("full status with room left");

    a_found_hits: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> (valid != '0))
        else $error("match reported on empty list");

endmodule

`default_nettype wire
